FILE: design/dfs_pkg.sv
// shared types, codes and reset values of the delimited field splitter
package dfs_pkg;

    // configuration port address width (seven 32-bit registers)
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SEPARATOR      = 3'd0;
    localparam logic [2:0] REG_QUOTE_A        = 3'd1;
    localparam logic [2:0] REG_QUOTE_B        = 3'd2;
    localparam logic [2:0] REG_QUOTE_ENABLE   = 3'd3;
    localparam logic [2:0] REG_COMMENT_CHAR   = 3'd4;
    localparam logic [2:0] REG_COMMENT_ENABLE = 3'd5;
    localparam logic [2:0] REG_SKIP_EMPTY     = 3'd6;

    // register reset values
    localparam logic [7:0] RST_SEPARATOR      = 8'd44;
    localparam logic [7:0] RST_QUOTE_A        = 8'd34;
    localparam logic [7:0] RST_QUOTE_B        = 8'd39;
    localparam logic [1:0] RST_QUOTE_ENABLE   = 2'd3;
    localparam logic [7:0] RST_COMMENT_CHAR   = 8'd35;
    localparam logic       RST_COMMENT_ENABLE = 1'b0;
    localparam logic       RST_SKIP_EMPTY     = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    // configuration seen by the tokenizer
    typedef struct packed {
        logic [7:0] separator_char;
        logic [7:0] quote_char_a;
        logic [7:0] quote_char_b;
        logic [1:0] quote_enable;
        logic [7:0] comment_char;
        logic       comment_enable;
        logic       skip_empty;
    } cfg_t;

endpackage

FILE: design/dfs_if.sv
// stream interfaces for the byte input and the result output
interface dfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_line_end;

    modport source (output valid, output char_code, output is_line_end, input ready);
    modport sink (input valid, input char_code, input is_line_end, output ready);
endinterface

interface dfs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] char_value;
    logic       last_of_line;

    modport source (output valid, output item_kind, output char_value, output last_of_line,
                    input ready);
    modport sink (input valid, input item_kind, input char_value, input last_of_line,
                  output ready);
endinterface

FILE: design/dfs_cfg_regs.sv
// configuration register file behind the APB-style port
module dfs_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dfs_pkg::ADDR_W-1:0] paddr,
    input  logic [dfs_pkg::DATA_W-1:0] pwdata,
    output logic [dfs_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output dfs_pkg::cfg_t             cfg
);
    import dfs_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator_char <= RST_SEPARATOR;
            cfg_reg.quote_char_a   <= RST_QUOTE_A;
            cfg_reg.quote_char_b   <= RST_QUOTE_B;
            cfg_reg.quote_enable   <= RST_QUOTE_ENABLE;
            cfg_reg.comment_char   <= RST_COMMENT_CHAR;
            cfg_reg.comment_enable <= RST_COMMENT_ENABLE;
            cfg_reg.skip_empty     <= RST_SKIP_EMPTY;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SEPARATOR:      cfg_reg.separator_char <= pwdata[7:0];
                REG_QUOTE_A:        cfg_reg.quote_char_a   <= pwdata[7:0];
                REG_QUOTE_B:        cfg_reg.quote_char_b   <= pwdata[7:0];
                REG_QUOTE_ENABLE:   cfg_reg.quote_enable   <= pwdata[1:0];
                REG_COMMENT_CHAR:   cfg_reg.comment_char   <= pwdata[7:0];
                REG_COMMENT_ENABLE: cfg_reg.comment_enable <= pwdata[0];
                REG_SKIP_EMPTY:     cfg_reg.skip_empty     <= pwdata[0];
                default:            ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SEPARATOR:      prdata = {24'd0, cfg_reg.separator_char};
            REG_QUOTE_A:        prdata = {24'd0, cfg_reg.quote_char_a};
            REG_QUOTE_B:        prdata = {24'd0, cfg_reg.quote_char_b};
            REG_QUOTE_ENABLE:   prdata = {30'd0, cfg_reg.quote_enable};
            REG_COMMENT_CHAR:   prdata = {24'd0, cfg_reg.comment_char};
            REG_COMMENT_ENABLE: prdata = {31'd0, cfg_reg.comment_enable};
            REG_SKIP_EMPTY:     prdata = {31'd0, cfg_reg.skip_empty};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: design/delimited_field_splitter.sv
// delimited field splitter: byte-serial tokenizer with quotes and comments
//
// byte_in carries one byte of a line per transfer, or a line-end marker
// (is_line_end high). item_out carries zero or one result per input item:
// a field byte, a field end, or a line end with no open field; the final
// result of each line has last_of_line set.
// The separator, quote and comment bytes and the options are set through
// the APB-style port; the user must change them only while the block is idle
// (the block itself does not enforce this). An item lands in the input register,
// is decoded combinationally, and its result is held in the result register for item_out.
// Throughput: one item per cycle while item_out is not stalled, set by the
// single decode step between the input register and the result register.
// Reset clears the quote, comment and field flags, empties both registers
// and loads the default configuration.
// When item_out is stalled the result register holds, the input register
// keeps one more item, and byte_in ready drops until the result is taken.
module delimited_field_splitter (
    input  logic                       clk,
    input  logic                       rst_n,
    dfs_byte_if.sink                   byte_in,
    dfs_item_if.source                 item_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfs_pkg::ADDR_W-1:0] paddr,
    input  logic [dfs_pkg::DATA_W-1:0] pwdata,
    output logic [dfs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dfs_pkg::*;

    cfg_t       cfg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_line_end_reg;

    // tokenizer state
    logic       in_quote_reg,  in_quote_next;
    logic [7:0] open_quote_reg, open_quote_next;
    logic       in_comment_reg, in_comment_next;
    logic       has_chars_reg, has_chars_next;

    // result register
    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_value_reg;
    logic       out_last_reg;

    // decode results
    logic       emit;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       field_emit;
    logic       quote_hit;
    logic       advance;

    dfs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: the decoded item moves on whenever the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || item_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    assign item_out.valid        = out_valid_reg;
    assign item_out.item_kind    = out_kind_reg;
    assign item_out.char_value   = out_value_reg;
    assign item_out.last_of_line = out_last_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_char_reg     <= byte_in.char_code;
            in_line_end_reg <= byte_in.is_line_end;
        end
    end

    // byte decode and state update
    assign field_emit = has_chars_reg || !cfg.skip_empty;
    assign quote_hit  = (cfg.quote_enable[0] && (in_char_reg == cfg.quote_char_a)) ||
                        (cfg.quote_enable[1] && (in_char_reg == cfg.quote_char_b));

    always_comb
    begin
        emit            = 1'b0;
        kind            = KIND_BYTE;
        value           = 8'd0;
        last            = 1'b0;
        in_quote_next   = in_quote_reg;
        open_quote_next = open_quote_reg;
        in_comment_next = in_comment_reg;
        has_chars_next  = has_chars_reg;
        priority if (in_line_end_reg)
        begin
            emit            = 1'b1;
            last            = 1'b1;
            kind            = (!in_comment_reg && field_emit) ? KIND_FIELD_END : KIND_LINE_END;
            in_quote_next   = 1'b0;
            open_quote_next = 8'd0;
            in_comment_next = 1'b0;
            has_chars_next  = 1'b0;
        end
        else if (in_comment_reg)
        begin
            emit = 1'b0;
        end
        else if (in_quote_reg)
        begin
            if (in_char_reg == open_quote_reg)
            begin
                in_quote_next   = 1'b0;
                open_quote_next = 8'd0;
            end
            else
            begin
                emit           = 1'b1;
                value          = in_char_reg;
                has_chars_next = 1'b1;
            end
        end
        else if (in_char_reg == cfg.separator_char)
        begin
            emit           = field_emit;
            kind           = KIND_FIELD_END;
            has_chars_next = 1'b0;
        end
        else if (cfg.comment_enable && (in_char_reg == cfg.comment_char))
        begin
            emit            = field_emit;
            kind            = KIND_FIELD_END;
            has_chars_next  = 1'b0;
            in_comment_next = 1'b1;
        end
        else if (quote_hit)
        begin
            in_quote_next   = 1'b1;
            open_quote_next = in_char_reg;
        end
        else
        begin
            emit           = 1'b1;
            value          = in_char_reg;
            has_chars_next = 1'b1;
        end
    end

    // tokenizer state, updated as each item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg   <= 1'b0;
            open_quote_reg <= 8'd0;
            in_comment_reg <= 1'b0;
            has_chars_reg  <= 1'b0;
        end
        else if (advance)
        begin
            in_quote_reg   <= in_quote_next;
            open_quote_reg <= open_quote_next;
            in_comment_reg <= in_comment_next;
            has_chars_reg  <= has_chars_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (item_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg  <= kind;
            out_value_reg <= value;
            out_last_reg  <= last;
        end
    end

endmodule

FILE: design/dfs_checker.sv
// port-level assertions for the delimited field splitter, bound to the top level
module dfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] item_kind,
    input logic [7:0] char_value,
    input logic       last_of_line
);
    import dfs_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(char_value))
        else $error("result dropped or changed while stalled");

    // only the three defined kinds are produced
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (item_kind == KIND_BYTE) || (item_kind == KIND_FIELD_END) ||
                      (item_kind == KIND_LINE_END))
        else $error("illegal item kind");

    // non-byte results carry a zero value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind != KIND_BYTE) |-> char_value == 8'd0)
        else $error("nonzero value on a non-byte result");

    // a line-end result always closes its line, and field bytes never do
    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((item_kind == KIND_LINE_END) == last_of_line) ||
                      (item_kind == KIND_FIELD_END))
        else $error("line marker inconsistent with item kind");

endmodule

bind delimited_field_splitter dfs_checker u_dfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (item_out.valid),
    .out_ready    (item_out.ready),
    .item_kind    (item_out.item_kind),
    .char_value   (item_out.char_value),
    .last_of_line (item_out.last_of_line)
);
